// File: rtl/kct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types, constants and helper functions for the keypad countdown
// timer: event kinds, field widths and the decimal digit split.
// ----------------------------------------------------------------------------
package kct_pkg;

	// Number of keypad entry slots and the width of the slot pointer.
	localparam int ENTRY_DIGITS = 4;
	localparam int SLOT_W       = $clog2(ENTRY_DIGITS);

	// Field widths.
	localparam int DIGIT_W = 4;
	localparam int MMSS_W  = 7;
	localparam int TICKS_W = 13;

	// Stream widths; the data widths are rounded up to whole bytes.
	localparam int S_TDATA_W = 8;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 1;

	// Timer constants.
	localparam logic [TICKS_W-1:0] SECS_PER_MIN = TICKS_W'(60);
	localparam logic [MMSS_W-1:0]  SEC_BORROW   = MMSS_W'(59);
	localparam logic [DIGIT_W-1:0] MAX_DIGIT    = DIGIT_W'(9);

	// Event kinds carried on the input stream.
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_DIGIT = 2'd1,
		KIND_START = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	// Result of one event, before it is split into decimal digits.
	typedef struct packed {
		logic              show;
		logic [MMSS_W-1:0] mm;
		logic [MMSS_W-1:0] ss;
		logic              alarm;
	} result_t;

	// Tens digit of a value below 100, by multiplying with 205/2048.
	function automatic logic [DIGIT_W-1:0] tens_of(input logic [MMSS_W-1:0] v);
		logic [14:0] prod;
		prod = 15'(v) * 15'(205);
		return prod[14:11];
	endfunction

	// Ones digit of a value below 100, given its tens digit.
	function automatic logic [DIGIT_W-1:0] ones_of(input logic [MMSS_W-1:0] v,
		input logic [DIGIT_W-1:0] tens);
		logic [MMSS_W-1:0] t10;
		t10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
		return DIGIT_W'(v - t10);
	endfunction

endpackage
`default_nettype wire

// File: rtl/keypad_countdown_timer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_countdown_timer_top
// Countdown timer set from a keypad, with tick, digit, start and clear events.
// Each event passes the input register, then the result register, before its
// result is offered downstream; a stall can hold it in either register.
// Throughput: one event per cycle; a stalled result holds the input register.
// Reset: arst_n clears the entry buffer, countdown, alarm and configuration.
// ----------------------------------------------------------------------------
module keypad_countdown_timer_top (
	input  wire                               clk,
	input  wire                               arst_n,
	// Configuration: display_enabled.
	input  wire                               cfg_we,
	input  wire                               cfg_wdata,
	// Input stream.
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [kct_pkg::S_TDATA_W-1:0]     s_tdata,  // [3:0] digit
	input  wire  [kct_pkg::S_TUSER_W-1:0]     s_tuser,  // [1:0] kind
	// Result stream.
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// [3:0] min_tens, [7:4] min_ones, [11:8] sec_tens, [15:12] sec_ones, [16] alarm
	output logic [kct_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [kct_pkg::M_TUSER_W-1:0]     m_tuser   // [0] show
);

	logic                        valid_s1;
	kct_pkg::kind_t              kind_s1;
	logic [kct_pkg::DIGIT_W-1:0] digit_s1;
	logic                        advance;
	kct_pkg::result_t            res;

	// The input register moves on when the result register is free or draining.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= kct_pkg::kind_t'(s_tuser);
			digit_s1 <= s_tdata[kct_pkg::DIGIT_W-1:0];
		end
	end

	kct_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.kind      (kind_s1),
		.digit     (digit_s1),
		.res       (res)
	);

	kct_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// File: rtl/kct_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kct_core
// Timer state and its update for one event: keypad entry buffer, mm:ss
// countdown, tick counter, run flag and alarm. Produces the result of the
// event in binary form.
// ----------------------------------------------------------------------------
module kct_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire                                cfg_wdata,
	input  wire                                step,
	input  wire kct_pkg::kind_t                kind,
	input  wire [kct_pkg::DIGIT_W-1:0]         digit,
	output kct_pkg::result_t                   res
);

	logic [kct_pkg::DIGIT_W-1:0] entry_q [kct_pkg::ENTRY_DIGITS];
	logic [kct_pkg::SLOT_W-1:0]  slot_q;
	logic [kct_pkg::MMSS_W-1:0]  mm_q, ss_q;
	logic [kct_pkg::TICKS_W-1:0] ticks_q;
	logic                        running_q, alarm_q, disp_en_q;

	logic [kct_pkg::MMSS_W-1:0]  mm_d, ss_d;
	logic [kct_pkg::TICKS_W-1:0] ticks_d, ticks_dec;
	logic                        running_d, alarm_d;
	logic [kct_pkg::DIGIT_W-1:0] digit_sat;
	logic [kct_pkg::MMSS_W-1:0]  load_mm, load_ss;

	// Digit keys above nine are stored as nine.
	assign digit_sat = (digit > kct_pkg::MAX_DIGIT) ? kct_pkg::MAX_DIGIT : digit;

	// Values loaded by the start key from the entry slots.
	assign load_mm = kct_pkg::MMSS_W'(entry_q[0]) * kct_pkg::MMSS_W'(10)
		+ kct_pkg::MMSS_W'(entry_q[1]);
	assign load_ss = kct_pkg::MMSS_W'(entry_q[2]) * kct_pkg::MMSS_W'(10)
		+ kct_pkg::MMSS_W'(entry_q[3]);

	assign ticks_dec = ticks_q - kct_pkg::TICKS_W'(1);

	// Next state of the countdown for the current event.
	always_comb begin
		mm_d      = mm_q;
		ss_d      = ss_q;
		ticks_d   = ticks_q;
		running_d = running_q;
		alarm_d   = alarm_q;
		unique case (kind)
			kct_pkg::KIND_TICK: begin
				if (running_q) begin
					ticks_d = ticks_dec;
					if (ss_q == '0 && mm_q != '0) begin
						mm_d = mm_q - kct_pkg::MMSS_W'(1);
						ss_d = kct_pkg::SEC_BORROW;
					end else if (ss_q != '0) begin
						ss_d = ss_q - kct_pkg::MMSS_W'(1);
					end
					if (ticks_dec == '0) begin
						alarm_d   = 1'b1;
						running_d = 1'b0;
					end
				end
			end
			kct_pkg::KIND_DIGIT: begin
			end
			kct_pkg::KIND_START: begin
				mm_d      = load_mm;
				ss_d      = load_ss;
				ticks_d   = kct_pkg::TICKS_W'(load_mm) * kct_pkg::SECS_PER_MIN
					+ kct_pkg::TICKS_W'(load_ss) + kct_pkg::TICKS_W'(1);
				running_d = 1'b1;
			end
			kct_pkg::KIND_CLEAR: begin
				mm_d    = '0;
				ss_d    = '0;
				alarm_d = 1'b0;
			end
		endcase
	end

	// A tick reports mm:ss from before its step; other events report after.
	always_comb begin
		res.show  = (kind == kct_pkg::KIND_TICK) && running_q && disp_en_q;
		res.mm    = (kind == kct_pkg::KIND_TICK) ? mm_q : mm_d;
		res.ss    = (kind == kct_pkg::KIND_TICK) ? ss_q : ss_d;
		res.alarm = alarm_d;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_en_q <= 1'b0;
		end else if (cfg_we) begin
			disp_en_q <= cfg_wdata;
		end
	end

	// Countdown state, updated once per event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q      <= '0;
			ss_q      <= '0;
			ticks_q   <= '0;
			running_q <= 1'b0;
			alarm_q   <= 1'b0;
		end else if (step) begin
			mm_q      <= mm_d;
			ss_q      <= ss_d;
			ticks_q   <= ticks_d;
			running_q <= running_d;
			alarm_q   <= alarm_d;
		end
	end

	// Keypad entry buffer with a wrapping slot pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			for (int i = 0; i < kct_pkg::ENTRY_DIGITS; i++) begin
				entry_q[i] <= '0;
			end
		end else if (step && kind == kct_pkg::KIND_DIGIT) begin
			entry_q[slot_q] <= digit_sat;
			slot_q          <= slot_q + kct_pkg::SLOT_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: rtl/kct_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kct_out_stage
// Result register: splits mm:ss into decimal digits and holds the packed
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
module kct_out_stage (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               load,
	input  wire kct_pkg::result_t             res,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [kct_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic [kct_pkg::M_TUSER_W-1:0]     m_tuser
);

	logic [kct_pkg::DIGIT_W-1:0] mt, mo, st, so;
	logic                        valid_s2;
	logic [kct_pkg::M_TDATA_W-1:0] data_s2;
	logic                          show_s2;

	// Decimal split of minutes and seconds.
	assign mt = kct_pkg::tens_of(res.mm);
	assign mo = kct_pkg::ones_of(res.mm, mt);
	assign st = kct_pkg::tens_of(res.ss);
	assign so = kct_pkg::ones_of(res.ss, st);

	// Valid flag: set on load, cleared when the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= {7'b0, res.alarm, so, st, mo, mt};
			show_s2 <= res.show;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = show_s2;

endmodule
`default_nettype wire

// File: rtl/kct_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kct_checker
// Port-level checks of the timer: result stall behavior, one result per
// event, bounded occupancy and decimal digit ranges.
// ----------------------------------------------------------------------------
module kct_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_tvalid,
	input wire                            s_tready,
	input wire                            m_tvalid,
	input wire                            m_tready,
	input wire [kct_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire [kct_pkg::M_TUSER_W-1:0]   m_tuser
);

	logic [1:0] pend_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// Events taken in but whose result has not been transferred out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	// A stalled result holds its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Every result transfer belongs to an earlier event.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 2'd0)
		else $error("result without a pending event");

	// With nothing pending and nothing arriving, no result appears.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 && !in_xfer |=> !m_tvalid)
		else $error("result appeared with no event");

	// At most two events are in flight.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many events in flight");

	// Displayed digits stay decimal.
	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= 4'd9 && m_tdata[7:4] <= 4'd9
			&& m_tdata[11:8] <= 4'd9 && m_tdata[15:12] <= 4'd9)
		else $error("display digit out of range");

endmodule

bind keypad_countdown_timer_top kct_checker u_kct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
